// File: hdl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants for the button click classifier
// Item structs, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  // timestamp arithmetic width (wrapping)
  localparam int TIME_BITS = 32;

  localparam int NOW_W    = 32;
  localparam int MS_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [MS_W-1:0]      ms_t;

  // event codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LEVEL    = 2'd0,
    REG_DEBOUNCE_MS     = 2'd1,
    REG_LONG_PRESS_MS   = 2'd2,
    REG_DOUBLE_CLICK_MS = 2'd3
  } cfg_reg_t;

  // register reset values
  localparam logic RST_ACTIVE_LEVEL    = 1'b0;
  localparam ms_t  RST_DEBOUNCE_MS     = 16'd30;
  localparam ms_t  RST_LONG_PRESS_MS   = 16'd1000;
  localparam ms_t  RST_DOUBLE_CLICK_MS = 16'd300;

  typedef struct packed {
    logic             pin_level;
    logic [NOW_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       stable_pressed;
  } out_item_t;

  // configuration bundle to the classifier core
  typedef struct packed {
    logic active_level;
    ms_t  debounce_ms;
    ms_t  long_press_ms;
    ms_t  double_click_ms;
  } cfg_t;

endpackage

`default_nettype wire

// File: hdl/bcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcc_cfg_regs: configuration register file
// Plain write port; registers reset to their documented defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bcc_pkg::CFG_DAT_W-1:0] cfg_data,
  output bcc_pkg::cfg_t                      cfg
);

  bcc_pkg::cfg_t cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level    <= bcc_pkg::RST_ACTIVE_LEVEL;
      cfg_r.debounce_ms     <= bcc_pkg::RST_DEBOUNCE_MS;
      cfg_r.long_press_ms   <= bcc_pkg::RST_LONG_PRESS_MS;
      cfg_r.double_click_ms <= bcc_pkg::RST_DOUBLE_CLICK_MS;
    end else if (cfg_we) begin
      case (bcc_pkg::cfg_reg_t'(cfg_index))
        bcc_pkg::REG_ACTIVE_LEVEL:    cfg_r.active_level    <= cfg_data[0];
        bcc_pkg::REG_DEBOUNCE_MS:     cfg_r.debounce_ms     <= cfg_data[bcc_pkg::MS_W-1:0];
        bcc_pkg::REG_LONG_PRESS_MS:   cfg_r.long_press_ms   <= cfg_data[bcc_pkg::MS_W-1:0];
        bcc_pkg::REG_DOUBLE_CLICK_MS: cfg_r.double_click_ms <= cfg_data[bcc_pkg::MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hdl/bcc_core.sv
// ----------------------------------------------------------------------------
// bcc_core: debounce and click classification state
// Holds the press/click state; computes one result per item and commits the
// new state when the item advances.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bcc_pkg::cfg_t      cfg,
  input  wire logic               adv,
  input  wire bcc_pkg::in_item_t  item,
  output bcc_pkg::out_item_t      res
);

  logic            raw_r,   raw_nxt;
  logic            deb_r,   deb_nxt;
  logic            long_r,  long_nxt;
  logic            pend_r,  pend_nxt;
  bcc_pkg::time_t  chg_r,   chg_nxt;
  bcc_pkg::time_t  press_r, press_nxt;
  bcc_pkg::time_t  click_r, click_nxt;

  bcc_pkg::time_t  now;
  bcc_pkg::time_t  el_chg;
  bcc_pkg::time_t  el_press;
  bcc_pkg::time_t  el_click;
  bcc_pkg::time_t  dbl_lim;
  logic            deb_ok;
  bcc_pkg::event_t ev;

  assign now     = bcc_pkg::TIME_BITS'(item.now_ms);
  assign dbl_lim = bcc_pkg::TIME_BITS'(cfg.double_click_ms);

  // raw level tracking and debounce timer
  always_comb begin
    raw_nxt = (item.pin_level == cfg.active_level);
    if (raw_nxt != raw_r) begin
      chg_nxt = now;
      el_chg  = '0;
    end else begin
      chg_nxt = chg_r;
      el_chg  = now - chg_r;
    end
    deb_ok = (el_chg >= bcc_pkg::TIME_BITS'(cfg.debounce_ms));
  end

  // press and click classification
  always_comb begin
    ev        = bcc_pkg::EV_NONE;
    deb_nxt   = deb_r;
    long_nxt  = long_r;
    pend_nxt  = pend_r;
    press_nxt = press_r;
    click_nxt = click_r;
    el_press  = now - press_r;
    el_click  = now - click_r;
    if (deb_ok) begin
      if (deb_r != raw_nxt) begin
        deb_nxt = raw_nxt;
        if (raw_nxt) begin
          press_nxt = now;
          el_press  = '0;
          long_nxt  = 1'b0;
        end else if (!long_r) begin
          if (pend_r && (el_click <= dbl_lim)) begin
            pend_nxt = 1'b0;
            ev       = bcc_pkg::EV_DOUBLE;
          end else begin
            pend_nxt  = 1'b1;
            click_nxt = now;
            el_click  = '0;
          end
        end
      end
      if (deb_nxt && !long_nxt &&
          (el_press >= bcc_pkg::TIME_BITS'(cfg.long_press_ms))) begin
        long_nxt = 1'b1;
        pend_nxt = 1'b0;
        ev       = bcc_pkg::EV_LONG;
      end
    end
    // pending click timeout
    if (pend_nxt && (el_click > dbl_lim)) begin
      pend_nxt = 1'b0;
      ev       = bcc_pkg::EV_SINGLE;
    end
  end

  // flag state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r  <= 1'b0;
      deb_r  <= 1'b0;
      long_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (adv) begin
      raw_r  <= raw_nxt;
      deb_r  <= deb_nxt;
      long_r <= long_nxt;
      pend_r <= pend_nxt;
    end
  end

  // timestamps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_r   <= '0;
      press_r <= '0;
      click_r <= '0;
    end else if (adv) begin
      chg_r   <= chg_nxt;
      press_r <= press_nxt;
      click_r <= click_nxt;
    end
  end

  assign res.event_res      = ev;
  assign res.stable_pressed = deb_nxt;

endmodule

`default_nettype wire

// File: hdl/button_click_classifier.sv
// ----------------------------------------------------------------------------
// button_click_classifier: debounced single, double and long press detector
//
// Input channel (in_valid/in_stall/in_data): one poll sample per item, the raw
// pin level and a free-running millisecond timestamp. Output channel
// (out_valid/out_stall/out_data): exactly one result per sample, an event code
// (none, single, double, long) and the debounced pressed level. Configuration
// (cfg_we/cfg_index/cfg_data) must be written only while idle (not enforced).
//
// An accepted sample lands in an input register, the classifier evaluates it
// combinationally and its result is loaded into the output register, which
// drives out_valid. The block takes one item per cycle while the receiver does
// not stall; the classifier state is committed as each item advances.
// When the receiver stalls, the held result stays in the output register and
// one more sample is still taken into the input register; after that in_stall
// rises until the output drains.
// Synchronous reset clears all press/click state and restores default
// register values; no item is held after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire bcc_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output bcc_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bcc_pkg::CFG_DAT_W-1:0] cfg_data
);

  bcc_pkg::cfg_t      cfg;
  logic               in_vld_r;
  bcc_pkg::in_item_t  in_item_r;
  logic               out_vld_r;
  bcc_pkg::out_item_t out_item_r;
  bcc_pkg::out_item_t res;
  logic               adv;
  logic               in_acc;

  bcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // item advances from input register to output register
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_data;
    end
  end

  bcc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .adv   (adv),
    .item  (in_item_r),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

// File: hdl/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker: port-level checks for the button click classifier
// Observes the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire bcc_pkg::out_item_t  out_data
);

  // no result is held right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input only backs up behind a stalled full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without output backpressure");

  // a long press is reported while pressed
  a_long_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == bcc_pkg::EV_LONG) |-> out_data.stable_pressed)
    else $error("long press reported while released");

  // a double click completes on a release
  a_double_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == bcc_pkg::EV_DOUBLE) |-> !out_data.stable_pressed)
    else $error("double click reported while pressed");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: button click classifier self-checking bench
// Feeds poll samples built as press/hold/release gestures with bounce, plus
// noise and timestamp jumps, across several register settings. A cycle-free
// model of the classifier predicts every result, which the output monitor
// compares field by field in order.
// ----------------------------------------------------------------------------

module testbench;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bcc_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bcc_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index = bcc_pkg::REG_ACTIVE_LEVEL;
  logic [bcc_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  // pending samples and predicted results
  bcc_pkg::in_item_t  sample_queue[$];
  bcc_pkg::out_item_t expected_events[$];
  int unsigned        error_count = 0;
  int unsigned        pushed_total = 0;
  bcc_pkg::time_t     clock_ms = '0;

  // driver and receiver control
  logic        in_fire = 1'b0;
  int unsigned gap_left = 0;
  int unsigned hold_cnt = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  logic        no_idle = 1'b0;

  // classifier model state and register copy
  bcc_pkg::cfg_t  model_cfg = '{bcc_pkg::RST_ACTIVE_LEVEL, bcc_pkg::RST_DEBOUNCE_MS,
                                bcc_pkg::RST_LONG_PRESS_MS, bcc_pkg::RST_DOUBLE_CLICK_MS};
  logic           raw_down = 1'b0;
  logic           stable_down = 1'b0;
  logic           long_done = 1'b0;
  logic           click_waiting = 1'b0;
  bcc_pkg::time_t t_change = '0;
  bcc_pkg::time_t t_press = '0;
  bcc_pkg::time_t t_click = '0;

  button_click_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // debounce, then classify releases into clicks and presses into long presses
  function automatic bcc_pkg::out_item_t classify_sample(bcc_pkg::in_item_t s);
    bcc_pkg::time_t     now;
    logic               down;
    bcc_pkg::event_t    ev;
    bcc_pkg::out_item_t r;
    now  = s.now_ms;
    down = (s.pin_level == model_cfg.active_level);
    ev   = bcc_pkg::EV_NONE;
    if (down != raw_down) begin
      raw_down = down;
      t_change = now;
    end
    if (bcc_pkg::time_t'(now - t_change) >=
        bcc_pkg::time_t'(model_cfg.debounce_ms)) begin
      if (stable_down != raw_down) begin
        stable_down = raw_down;
        if (stable_down) begin
          t_press   = now;
          long_done = 1'b0;
        end else if (!long_done) begin
          if (click_waiting &&
              bcc_pkg::time_t'(now - t_click) <=
              bcc_pkg::time_t'(model_cfg.double_click_ms)) begin
            click_waiting = 1'b0;
            ev = bcc_pkg::EV_DOUBLE;
          end else begin
            click_waiting = 1'b1;
            t_click = now;
          end
        end
      end
      if (stable_down && !long_done &&
          bcc_pkg::time_t'(now - t_press) >=
          bcc_pkg::time_t'(model_cfg.long_press_ms)) begin
        long_done     = 1'b1;
        click_waiting = 1'b0;
        ev = bcc_pkg::EV_LONG;
      end
    end
    // pending click timed out
    if (click_waiting && bcc_pkg::time_t'(now - t_click) >
        bcc_pkg::time_t'(model_cfg.double_click_ms)) begin
      click_waiting = 1'b0;
      ev = bcc_pkg::EV_SINGLE;
    end
    r.event_res      = ev;
    r.stable_pressed = stable_down;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // input driver: new item only after the current one was taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sample_queue.size() != 0) begin
        in_data  <= sample_queue.pop_front();
        in_valid <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (holds_done < holds_asked) begin
      out_stall  <= 1'b1;
      hold_cnt   <= 99;
      holds_done <= holds_done + 1;
    end else if (no_idle || r < 65) begin
      out_stall <= 1'b0;
    end else if (r < 92) begin
      out_stall <= 1'b1;
      hold_cnt  <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b1;
      hold_cnt  <= $urandom_range(7, 29);
    end
  end

  // monitors: check results, predict accepted items
  always @(posedge clk) begin
    bcc_pkg::out_item_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $error("result with no item outstanding: event_res %0d stable_pressed %0b",
               out_data.event_res, out_data.stable_pressed);
        error_count++;
      end else begin
        want = expected_events.pop_front();
        if (out_data.event_res !== want.event_res) begin
          $error("event_res mismatch: expected %0d, got %0d",
                 want.event_res, out_data.event_res);
          error_count++;
        end
        if (out_data.stable_pressed !== want.stable_pressed) begin
          $error("stable_pressed mismatch: expected %0b, got %0b",
                 want.stable_pressed, out_data.stable_pressed);
          error_count++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall)
      expected_events.push_back(classify_sample(in_data));
  end

  task automatic emit(input logic level, input int unsigned delta);
    bcc_pkg::in_item_t s;
    clock_ms    = clock_ms + delta;
    s.pin_level = level;
    s.now_ms    = clock_ms;
    sample_queue.push_back(s);
    pushed_total++;
  endtask

  task automatic emit_at(input logic level, input bcc_pkg::time_t t);
    clock_ms = t;
    emit(level, 0);
  endtask

  function automatic int unsigned short_step(input int unsigned deb);
    return (deb == 0) ? 0 : $urandom_range(0, deb - 1);
  endfunction

  // value on or next to a threshold, or anywhere up to twice it plus two
  function automatic int unsigned around(input int unsigned b);
    case ($urandom_range(0, 3))
      0: return (b == 0) ? 0 : b - 1;
      1: return b;
      2: return b + 1;
      default: return $urandom_range(0, 2 * b + 2);
    endcase
  endfunction

  // one press and release with bounce on both edges, then an idle gap
  task automatic add_gesture();
    logic        p;
    int unsigned deb, lp, dc, hold, gap, n, k, lim;
    p   = model_cfg.active_level;
    deb = 32'(model_cfg.debounce_ms);
    lp  = 32'(model_cfg.long_press_ms);
    dc  = 32'(model_cfg.double_click_ms);
    k = $urandom_range(0, 3);
    repeat (k) begin
      emit(p, short_step(deb));
      emit(!p, short_step(deb));
    end
    emit(p, short_step(deb));
    emit(p, around(deb));
    // hold: quick click, plain click, long press or right at the long-press time
    lim = (dc / 3 < lp) ? dc / 3 : lp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: hold = $urandom_range(0, lim);
      4:          hold = $urandom_range(0, lp);
      5, 6, 7:    hold = lp + $urandom_range(0, lp + 50);
      default:    hold = around(lp);
    endcase
    n = $urandom_range(1, 4);
    repeat (n) emit(p, hold / n);
    k = $urandom_range(0, 2);
    repeat (k) begin
      emit(!p, short_step(deb));
      emit(p, short_step(deb));
    end
    emit(!p, short_step(deb));
    emit(!p, around(deb));
    // idle: inside, at or past the double-click window
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: gap = $urandom_range(0, dc / 3);
      5, 6:          gap = around(dc);
      default:       gap = dc + $urandom_range(1, 3000);
    endcase
    n = $urandom_range(0, 3);
    if (n == 0) clock_ms = clock_ms + gap;
    else repeat (n) emit(!p, gap / n);
  endtask

  // random level, small step or a jump anywhere in the timestamp range
  task automatic add_noise();
    if ($urandom_range(0, 4) == 0) clock_ms = $urandom;
    emit(1'($urandom_range(0, 1)), $urandom_range(0, 2 * model_cfg.debounce_ms + 4));
  endtask

  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input bcc_pkg::cfg_reg_t idx, input bcc_pkg::ms_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      bcc_pkg::REG_ACTIVE_LEVEL:    model_cfg.active_level    = val[0];
      bcc_pkg::REG_DEBOUNCE_MS:     model_cfg.debounce_ms     = val;
      bcc_pkg::REG_LONG_PRESS_MS:   model_cfg.long_press_ms   = val;
      bcc_pkg::REG_DOUBLE_CLICK_MS: model_cfg.double_click_ms = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic act, input int unsigned deb,
                            input int unsigned lp, input int unsigned dc);
    write_reg(bcc_pkg::REG_ACTIVE_LEVEL, bcc_pkg::ms_t'(act));
    write_reg(bcc_pkg::REG_DEBOUNCE_MS, bcc_pkg::ms_t'(deb));
    write_reg(bcc_pkg::REG_LONG_PRESS_MS, bcc_pkg::ms_t'(lp));
    write_reg(bcc_pkg::REG_DOUBLE_CLICK_MS, bcc_pkg::ms_t'(dc));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start;
    start = pushed_total;
    while (pushed_total - start < count) begin
      if ($urandom_range(0, 9) < 8) add_gesture();
      else repeat ($urandom_range(1, 4)) add_noise();
    end
    wait_drained();
  endtask

  // run limit
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings (pressed is pin low)
    emit_at(1'b1, 32'd0);
    emit_at(1'b0, 32'd10);          // bounce
    emit_at(1'b1, 32'd15);
    emit_at(1'b0, 32'd20);
    emit_at(1'b0, 32'd50);          // debounced exactly at the limit
    emit_at(1'b1, 32'd100);
    emit_at(1'b1, 32'd130);         // click pending
    emit_at(1'b0, 32'd200);
    emit_at(1'b0, 32'd230);
    emit_at(1'b1, 32'd240);
    emit_at(1'b1, 32'd270);         // double click
    emit_at(1'b0, 32'd300);
    emit_at(1'b0, 32'd330);
    emit_at(1'b0, 32'd1330);        // long press exactly at the limit
    emit_at(1'b1, 32'd1400);
    emit_at(1'b1, 32'd1430);        // release after long press
    emit_at(1'b0, 32'd1500);
    emit_at(1'b0, 32'd1530);
    emit_at(1'b1, 32'd1600);
    emit_at(1'b1, 32'd1630);
    emit_at(1'b1, 32'd1930);        // still inside the window
    emit_at(1'b1, 32'd1931);        // single press
    emit_at(1'b1, 32'hFFFF_FFF0);
    emit_at(1'b0, 32'hFFFF_FFFF);
    emit_at(1'b0, 32'h0000_0020);   // debounce across the wrap
    emit_at(1'b1, 32'd5);           // backward jump
    emit_at(1'b1, 32'hFFFF_FFFF);
    wait_drained();

    // all thresholds zero, active high
    set_config(1'b1, 0, 0, 0);
    run_random(60);

    // all thresholds at maximum, starting just below the wrap
    set_config(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    clock_ms = 32'hFFFF_0000;
    run_random(50);

    // no idling, one long receiver hold-off so the block backs up
    set_config(1'b0, 30, 1000, 300);
    no_idle = 1'b1;
    run_random(60);
    no_idle = 1'b0;
    holds_asked++;
    run_random(20);

    // random settings
    repeat (5) begin
      set_config(1'($urandom_range(0, 1)), $urandom_range(0, 60),
                 $urandom_range(0, 1500), $urandom_range(0, 600));
      run_random(80);
    end

    repeat (10) @(posedge clk);
    if (expected_events.size() != 0) begin
      $error("%0d results never arrived", expected_events.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/bcc_pkg.sv
hdl/bcc_cfg_regs.sv
hdl/bcc_core.sv
hdl/button_click_classifier.sv
hdl/bcc_checker.sv
test/testbench.sv
